### rtl/osp_pkg.sv
// Shared types, constants and a helper function for the overbuffer send pacer.
package osp_pkg;

  // Field widths fixed by the item formats
  localparam int TIME_BITS              = 48;
  localparam int BYTES_BITS             = 40;
  localparam int WINDOW_BITS            = 32;
  localparam int INTERVAL_BITS          = 16;
  localparam int AHEAD_MS_BITS          = 26;
  localparam int PKT_BITS               = 16;
  localparam int CFG_INDEX_BITS         = 8;
  localparam int CFG_DATA_BITS          = 32;
  localparam int RATE_FRAC_BITS_DEFAULT = 8;

  // Pacing constants
  localparam logic [INTERVAL_BITS-1:0] DEFAULT_INTERVAL_MS = 16'd200;
  localparam logic [TIME_BITS-1:0]     DUE_SLACK_MS        = TIME_BITS'(1000);
  localparam int                       MS_PER_SECOND       = 1000;
  localparam int                       WINDOW_FACTOR       = 5;

  // Register reset values
  localparam logic [INTERVAL_BITS-1:0]      RESET_INTERVAL_MS = 16'd200;
  localparam logic signed [WINDOW_BITS-1:0] WINDOW_UNLIMITED  = -32'sd1;
  localparam logic [AHEAD_MS_BITS-1:0]      RESET_MAX_AHEAD_MS = 26'd20000;
  localparam logic [15:0]                   RESET_RATE_Q      = 16'd512;

  localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [BYTES_BITS-1:0] BYTES_MAX = {BYTES_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_CHECK        = 2'd0,
    OP_ADD_BYTES    = 2'd1,
    OP_SET_WINDOW   = 2'd2,
    OP_RESET_WINDOW = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SEND_INTERVAL = 8'd0,
    CFG_INIT_WINDOW   = 8'd1,
    CFG_MAX_AHEAD     = 8'd2,
    CFG_RATE          = 8'd3
  } cfg_index_t;

  typedef struct packed {
    op_t                             operation;
    logic [TIME_BITS-1:0]            due_time;
    logic [TIME_BITS-1:0]            now_time;
    logic [PKT_BITS-1:0]             packet_bytes;
    logic signed [WINDOW_BITS-1:0]   new_window_bytes;
  } in_item_t;

  typedef struct packed {
    logic                 send_now;
    logic [TIME_BITS-1:0] release_time;
  } out_item_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [INTERVAL_BITS-1:0]      send_interval;
    logic signed [WINDOW_BITS-1:0] init_window;
    logic [AHEAD_MS_BITS-1:0]      max_ahead_ms;
    logic [15:0]                   rate_q;
    logic                          window_load;
  } cfg_t;

  // Pacing state carried from item to item
  typedef struct packed {
    logic [TIME_BITS-1:0]          bucket_start;
    logic [TIME_BITS-1:0]          prior_bucket_start;
    logic [TIME_BITS-1:0]          ahead_now;
    logic [TIME_BITS-1:0]          ahead_before;
    logic signed [WINDOW_BITS-1:0] window_bytes;
    logic [BYTES_BITS-1:0]         bytes_since_report;
  } state_t;

  // Time sum that saturates at the top of the time range
  function automatic logic [TIME_BITS-1:0] time_sat_add(input logic [TIME_BITS-1:0] a,
                                                        input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

endpackage

### rtl/osp_cfg_regs.sv
// Configuration register file for the overbuffer send pacer.
module osp_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [osp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [osp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output osp_pkg::cfg_t                        cfg
);

  logic [osp_pkg::INTERVAL_BITS-1:0]      send_interval;
  logic signed [osp_pkg::WINDOW_BITS-1:0] init_window;
  logic [osp_pkg::AHEAD_MS_BITS-1:0]      max_ahead_ms;
  logic [15:0]                            rate_q;
  logic                                   window_load;
  logic [osp_pkg::AHEAD_MS_BITS-1:0]      max_ahead_next;

  assign cfg_ready = 1'b1;

  // Convert seconds to ms once, at write time
  assign max_ahead_next = osp_pkg::AHEAD_MS_BITS'(cfg_data[15:0]) *
                          osp_pkg::AHEAD_MS_BITS'(osp_pkg::MS_PER_SECOND);

  // Write the addressed register; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      send_interval <= osp_pkg::RESET_INTERVAL_MS;
      init_window   <= osp_pkg::WINDOW_UNLIMITED;
      max_ahead_ms  <= osp_pkg::RESET_MAX_AHEAD_MS;
      rate_q        <= osp_pkg::RESET_RATE_Q;
      window_load   <= 1'b0;
    end else begin
      window_load <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          osp_pkg::CFG_SEND_INTERVAL: send_interval <= cfg_data[15:0];
          osp_pkg::CFG_INIT_WINDOW: begin
            init_window <= $signed(cfg_data);
            window_load <= 1'b1;
          end
          osp_pkg::CFG_MAX_AHEAD:     max_ahead_ms <= max_ahead_next;
          osp_pkg::CFG_RATE:          rate_q <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.send_interval = send_interval;
  assign cfg.init_window   = init_window;
  assign cfg.max_ahead_ms  = max_ahead_ms;
  assign cfg.rate_q        = rate_q;
  assign cfg.window_load   = window_load;

endmodule

### rtl/osp_decide.sv
// Pacing decision and next-state logic for one item.
module osp_decide #(
  parameter int RATE_FRAC_BITS = osp_pkg::RATE_FRAC_BITS_DEFAULT
) (
  input  osp_pkg::in_item_t   item,
  input  osp_pkg::state_t     st,
  input  osp_pkg::cfg_t       cfg,
  output osp_pkg::state_t     st_next,
  output logic                has_result,
  output osp_pkg::out_item_t  res
);

  localparam int TB = osp_pkg::TIME_BITS;
  localparam int BB = osp_pkg::BYTES_BITS;
  localparam int WB = osp_pkg::WINDOW_BITS;
  localparam int PB = TB + 16;
  localparam int X5 = osp_pkg::PKT_BITS + 3;
  localparam logic [16:0] RATE_ONE = 17'(2 ** RATE_FRAC_BITS);

  logic                   enabled;
  logic [15:0]            ivl;
  logic [TB-1:0]          ivl_t;
  logic [TB-1:0]          ivl5_t;
  logic [TB-1:0]          now;
  logic [TB-1:0]          due;
  logic                   roll;
  logic [TB-1:0]          bs_r;
  logic [TB-1:0]          pbs_r;
  logic [TB-1:0]          ab_r;
  logic [TB-1:0]          due_soon_t1;
  logic [TB-1:0]          due_soon_t2;
  logic                   due_soon;
  logic [X5-1:0]          pkt5;
  logic signed [BB+1:0]   win_room;
  logic signed [BB+1:0]   pkt5_s;
  logic                   window_low;
  logic [TB-1:0]          ahead;
  logic [TB-1:0]          max_ahead_t;
  logic                   over_max;
  logic [16:0]            rate17;
  logic [15:0]            rate_k;
  logic [TB-1:0]          elapsed;
  logic [PB-1:0]          prod;
  logic [PB-1:0]          prod_sh;
  logic [TB-1:0]          cap;
  logic                   over_cap;
  logic [BB:0]            bytes_sum;

  // Interval, with zero meaning overbuffering off
  assign enabled = (cfg.send_interval != '0);
  assign ivl     = enabled ? cfg.send_interval : osp_pkg::DEFAULT_INTERVAL_MS;
  assign ivl_t   = TB'(ivl);
  assign ivl5_t  = TB'(ivl) * TB'(osp_pkg::WINDOW_FACTOR);
  assign now     = item.now_time;
  assign due     = item.due_time;

  // Roll the bucket when the current one has expired
  assign roll  = (now > st.bucket_start) && ((now - st.bucket_start) > ivl_t);
  assign bs_r  = roll ? now : st.bucket_start;
  assign ab_r  = roll ? st.ahead_now : st.ahead_before;
  always_comb begin
    pbs_r = st.prior_bucket_start;
    if (roll) begin
      if (st.bucket_start == '0) begin
        pbs_r = (now > ivl_t) ? (now - ivl_t) : '0;
      end else begin
        pbs_r = st.bucket_start;
      end
    end
  end

  // Due-soon window
  assign due_soon_t1 = osp_pkg::time_sat_add(now, ivl_t);
  assign due_soon_t2 = osp_pkg::time_sat_add(due_soon_t1, osp_pkg::DUE_SLACK_MS);
  assign due_soon    = due <= (enabled ? due_soon_t2 : due_soon_t1);

  // Client window room, compared signed
  assign pkt5     = X5'(item.packet_bytes) * X5'(osp_pkg::WINDOW_FACTOR);
  assign pkt5_s   = $signed((BB+2)'(pkt5));
  assign win_room = $signed({{(BB+2-WB){st.window_bytes[WB-1]}}, st.window_bytes})
                  - $signed({2'b00, st.bytes_since_report});
  assign window_low = (st.window_bytes != osp_pkg::WINDOW_UNLIMITED) && (pkt5_s > win_room);

  // Send-ahead limit
  assign ahead       = due - now;
  assign max_ahead_t = TB'(cfg.max_ahead_ms);
  assign over_max    = ahead > max_ahead_t;

  // Rate cap: floor(elapsed * (rate - 1.0)), saturated
  assign rate17  = {1'b0, cfg.rate_q};
  assign rate_k  = (rate17 < RATE_ONE) ? '0 : 16'(rate17 - RATE_ONE);
  assign elapsed = (now >= pbs_r) ? (now - pbs_r) : '0;
  assign prod    = PB'(elapsed) * PB'(rate_k);
  assign prod_sh = prod >> RATE_FRAC_BITS;
  assign cap     = (|prod_sh[PB-1:TB]) ? osp_pkg::TIME_MAX : prod_sh[TB-1:0];
  assign over_cap = (ahead - ab_r) > cap;

  assign bytes_sum = {1'b0, st.bytes_since_report} + (BB+1)'(item.packet_bytes);

  // Select the result and the next state
  always_comb begin
    st_next    = st;
    has_result = 1'b0;
    res        = '0;
    unique case (item.operation)
      osp_pkg::OP_ADD_BYTES: begin
        st_next.bytes_since_report = bytes_sum[BB] ? osp_pkg::BYTES_MAX : bytes_sum[BB-1:0];
      end
      osp_pkg::OP_SET_WINDOW: begin
        st_next.window_bytes       = item.new_window_bytes;
        st_next.bytes_since_report = '0;
      end
      osp_pkg::OP_RESET_WINDOW: begin
        st_next.bucket_start = '0;
        st_next.ahead_now    = '0;
        st_next.ahead_before = '0;
      end
      osp_pkg::OP_CHECK: begin
        has_result                 = 1'b1;
        st_next.bucket_start       = bs_r;
        st_next.prior_bucket_start = pbs_r;
        st_next.ahead_before       = ab_r;
        priority if (due_soon) begin
          res.send_now = 1'b1;
        end else if (!enabled || st.window_bytes == '0) begin
          res.release_time = due;
        end else if (window_low) begin
          res.release_time = osp_pkg::time_sat_add(now, ivl5_t);
        end else if (over_max) begin
          res.release_time = osp_pkg::time_sat_add(due - max_ahead_t, ivl_t);
        end else if (ahead < ab_r) begin
          st_next.ahead_now = ahead;
          res.send_now      = 1'b1;
        end else if (over_cap) begin
          st_next.ahead_now = osp_pkg::time_sat_add(ab_r, cap);
          res.release_time  = osp_pkg::time_sat_add(now, ivl_t);
        end else begin
          st_next.ahead_now = ahead;
          res.send_now      = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/overbuffer_send_pacer_core.sv
// Top level of the overbuffer send pacer: item stage, pacing state and result register.
//
//   Channel  Direction  Handshake                Payload
//   item     in         item_valid/item_ready    item (osp_pkg::in_item_t)
//   result   out        result_valid/result_ready result (osp_pkg::out_item_t)
//   cfg      in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// An item is registered on acceptance and decided from the item stage; a check
// loads its result into the result register as it leaves the stage, and one item
// is taken per cycle while no result is stalled. The combinational path from the
// state registers through the rate-cap multiply back to the state sets the clock rate.
// Reset restores register defaults; pacing state clears, but the window goes unlimited.
// A stalled result holds the item stage; non-check items pass it freely.
module overbuffer_send_pacer_core #(
  parameter int RATE_FRAC_BITS = osp_pkg::RATE_FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  osp_pkg::in_item_t                  item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output osp_pkg::out_item_t                 result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [osp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [osp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  osp_pkg::cfg_t      cfg;
  osp_pkg::state_t    state;
  osp_pkg::state_t    state_next;
  osp_pkg::in_item_t  stage_item;
  logic               stage_valid;
  logic               has_result;
  osp_pkg::out_item_t res;
  logic               advance;

  osp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  osp_decide #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_decide (
    .item       (stage_item),
    .st         (state),
    .cfg        (cfg),
    .st_next    (state_next),
    .has_result (has_result),
    .res        (res)
  );

  // Move the staged item on unless its result has nowhere to go
  assign advance    = stage_valid && (!has_result || !result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  // Item stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  // Pacing state; a window register write reloads the window
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{bucket_start:       '0,
                 prior_bucket_start: '0,
                 ahead_now:          '0,
                 ahead_before:       '0,
                 window_bytes:       osp_pkg::WINDOW_UNLIMITED,
                 bytes_since_report: '0};
    end else if (cfg.window_load) begin
      state <= '{bucket_start:       state.bucket_start,
                 prior_bucket_start: state.prior_bucket_start,
                 ahead_now:          state.ahead_now,
                 ahead_before:       state.ahead_before,
                 window_bytes:       cfg.init_window,
                 bytes_since_report: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && has_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      result <= res;
    end
  end

  // A check leaving the stage always shows up as a result
  a_check_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && stage_item.operation == osp_pkg::OP_CHECK |=> result_valid)
    else $error("check item produced no result");

  // Other operations never create a result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    advance && stage_item.operation != osp_pkg::OP_CHECK && !result_valid |=> !result_valid)
    else $error("non-check item produced a result");

  // Send-now results carry a zero release time
  a_send_now_zero_time: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.send_now |-> result.release_time == '0)
    else $error("send-now result with nonzero release time");

  // Reset-window clears the bucket and ahead tracking
  a_reset_window_clears: assert property (@(posedge clk) disable iff (rst)
    advance && stage_item.operation == osp_pkg::OP_RESET_WINDOW |=>
      state.bucket_start == '0 && state.ahead_now == '0 && state.ahead_before == '0)
    else $error("reset-window left pacing state");

  // A held stage keeps its item
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("stalled item stage changed");

endmodule

### bench/tb.sv
// Self-checking bench for the overbuffer send pacer: directed table, then randomized phases.
module tb;

  localparam int FRAC = osp_pkg::RATE_FRAC_BITS_DEFAULT;
  localparam longint unsigned RATE_ONE = 64'd1 << FRAC;
  localparam longint unsigned T_MAX = 64'(osp_pkg::TIME_MAX);
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 119;

  typedef struct {
    osp_pkg::in_item_t    it;
    bit                   pin;
    osp_pkg::out_item_t   want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  osp_pkg::in_item_t item;
  logic result_valid;
  logic result_ready;
  osp_pkg::out_item_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [osp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [osp_pkg::CFG_DATA_BITS-1:0] cfg_data;

  // Expected value typed into the table, travels with its item
  logic pin_on;
  osp_pkg::out_item_t pin_val;

  bit calm;
  int errors;
  osp_pkg::out_item_t pending_decisions[$];
  plan_row_t plan[$];

  // Shadow configuration and pacing state
  logic [15:0] cfg_ivl;
  longint cfg_win;
  logic [15:0] cfg_ahead_s;
  logic [15:0] cfg_rate;
  longint unsigned bkt_start;
  longint unsigned prior_start;
  longint unsigned ahead_cur;
  longint unsigned ahead_prev;
  longint win;
  longint unsigned sent_bytes;
  longint unsigned stream_ms;

  overbuffer_send_pacer_core DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned ms_sat_add(input longint unsigned a,
                                                 input longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > T_MAX) ? T_MAX : s;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic void clear_pacer();
    cfg_ivl = osp_pkg::RESET_INTERVAL_MS;
    cfg_win = -1;
    cfg_ahead_s = 16'd20;
    cfg_rate = osp_pkg::RESET_RATE_Q;
    bkt_start = 0;
    prior_start = 0;
    ahead_cur = 0;
    ahead_prev = 0;
    win = -1;
    sent_bytes = 0;
  endfunction

  function automatic void load_register(input logic [osp_pkg::CFG_INDEX_BITS-1:0] idx,
                                        input logic [31:0] d);
    case (idx)
      osp_pkg::CFG_SEND_INTERVAL: cfg_ivl = d[15:0];
      osp_pkg::CFG_INIT_WINDOW: begin
        cfg_win = longint'($signed(d));
        win = cfg_win;
        sent_bytes = 0;
      end
      osp_pkg::CFG_MAX_AHEAD: cfg_ahead_s = d[15:0];
      osp_pkg::CFG_RATE: cfg_rate = d[15:0];
      default: ;
    endcase
  endfunction

  // Work out the pacing decision for one item; returns 1 when a result is due
  function automatic bit decide_packet(input osp_pkg::in_item_t it,
                                       output osp_pkg::out_item_t r);
    longint unsigned due, now, pkt, ivl, lim, ahead, rate, k, elapsed, cap;
    bit on;
    due = 64'(it.due_time);
    now = 64'(it.now_time);
    pkt = 64'(it.packet_bytes);
    on = (cfg_ivl != 0);
    ivl = on ? 64'(cfg_ivl) : 64'd200;
    r = '0;
    case (it.operation)
      osp_pkg::OP_ADD_BYTES: begin
        sent_bytes = sent_bytes + pkt;
        if (sent_bytes > 64'(osp_pkg::BYTES_MAX)) sent_bytes = 64'(osp_pkg::BYTES_MAX);
        return 1'b0;
      end
      osp_pkg::OP_SET_WINDOW: begin
        win = longint'(it.new_window_bytes);
        sent_bytes = 0;
        return 1'b0;
      end
      osp_pkg::OP_RESET_WINDOW: begin
        bkt_start = 0;
        ahead_cur = 0;
        ahead_prev = 0;
        return 1'b0;
      end
      default: ;
    endcase
    // roll the bucket once the interval has passed
    if (now > bkt_start && now - bkt_start > ivl) begin
      prior_start = bkt_start;
      bkt_start = now;
      if (prior_start == 0) prior_start = (now > ivl) ? now - ivl : 0;
      ahead_prev = ahead_cur;
    end
    if (due <= ms_sat_add(now, ivl) ||
        (on && due <= ms_sat_add(ms_sat_add(now, ivl), 64'd1000))) begin
      r.send_now = 1'b1;
      return 1'b1;
    end
    if (!on || win == 0) begin
      r.release_time = due[47:0];
      return 1'b1;
    end
    if (win != -1 && longint'(pkt * 5) > win - longint'(sent_bytes)) begin
      r.release_time = 48'(ms_sat_add(now, ivl * 5));
      return 1'b1;
    end
    lim = 64'(cfg_ahead_s) * 64'd1000;
    if (due - now > lim) begin
      r.release_time = 48'(ms_sat_add(due - lim, ivl));
      return 1'b1;
    end
    ahead = due - now;
    ahead_cur = ahead;
    if (ahead < ahead_prev) begin
      r.send_now = 1'b1;
      return 1'b1;
    end
    // cap the gain in send-ahead by the overbuffer rate
    rate = (64'(cfg_rate) < RATE_ONE) ? RATE_ONE : 64'(cfg_rate);
    k = rate - RATE_ONE;
    elapsed = (now >= prior_start) ? now - prior_start : 0;
    cap = ms_sat_add((elapsed >> FRAC) * k, ((elapsed & (RATE_ONE - 1)) * k) >> FRAC);
    if (ahead - ahead_prev > cap) begin
      ahead_cur = ms_sat_add(ahead_prev, cap);
      r.release_time = 48'(ms_sat_add(now, ivl));
      return 1'b1;
    end
    r.send_now = 1'b1;
    return 1'b1;
  endfunction

  // Draw one item: mostly a plausible packet stream, some noise
  function automatic osp_pkg::in_item_t draw_item();
    osp_pkg::in_item_t it;
    int pick;
    longint unsigned ivl, lim, due;
    ivl = (cfg_ivl != 0) ? 64'(cfg_ivl) : 64'd200;
    lim = 64'(cfg_ahead_s) * 64'd1000;
    pick = $urandom_range(0, 99);
    it.operation = osp_pkg::op_t'($urandom_range(0, 3));
    it.due_time = rand48();
    it.now_time = rand48();
    it.packet_bytes = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(40, 1500));
    it.new_window_bytes = 32'($urandom);
    if (pick >= 94) return it;
    if (pick < 68) begin
      it.operation = osp_pkg::OP_CHECK;
      case ($urandom_range(0, 19))
        0: stream_ms = 64'(rand48());
        1: stream_ms = (stream_ms > 3000) ? stream_ms - $urandom_range(1, 3000) : 0;
        default: stream_ms = ms_sat_add(stream_ms, $urandom_range(0, 2 * ivl));
      endcase
      it.now_time = stream_ms[47:0];
      case ($urandom_range(0, 9))
        0: due = (stream_ms > 2000) ? stream_ms - $urandom_range(0, 2000) : 0;
        1, 2: due = stream_ms + $urandom_range(0, ivl + 1100);
        3, 4, 5, 6: due = stream_ms + ivl + 1000 + $urandom_range(1, lim + 2000);
        7: begin
          due = stream_ms + lim + $urandom_range(0, 4);
          due = (due >= 2) ? due - 2 : 0;
        end
        8: due = 64'(rand48());
        default: due = T_MAX - $urandom_range(0, 3);
      endcase
      it.due_time = 48'(ms_sat_add(due, 64'd0));
    end else if (pick < 82) begin
      it.operation = osp_pkg::OP_ADD_BYTES;
    end else if (pick < 90) begin
      it.operation = osp_pkg::OP_SET_WINDOW;
      case ($urandom_range(0, 5))
        0: it.new_window_bytes = '0;
        1: it.new_window_bytes = -32'sd1;
        2: it.new_window_bytes = 32'($urandom);
        default: it.new_window_bytes = 32'($urandom_range(0, 200000));
      endcase
    end else begin
      it.operation = osp_pkg::OP_RESET_WINDOW;
    end
    return it;
  endfunction

  function automatic osp_pkg::in_item_t mk(input osp_pkg::op_t op, input logic [47:0] due,
                                           input logic [47:0] now, input logic [15:0] pkt,
                                           input logic [31:0] nw);
    osp_pkg::in_item_t it;
    it.operation = op;
    it.due_time = due;
    it.now_time = now;
    it.packet_bytes = pkt;
    it.new_window_bytes = nw;
    return it;
  endfunction

  function automatic void add_row(input osp_pkg::in_item_t it, input bit pin, input bit snd,
                                  input logic [47:0] rel);
    plan_row_t row;
    row.it = it;
    row.pin = pin;
    row.want.send_now = snd;
    row.want.release_time = rel;
    plan.push_back(row);
  endfunction

  // Check results against the oldest expectation, then predict accepted items
  always @(posedge clk) begin
    osp_pkg::out_item_t e;
    osp_pkg::out_item_t p;
    if (rst) begin
      clear_pacer();
    end else begin
      if (result_valid && result_ready) begin
        if (pending_decisions.size() == 0) begin
          $error("result with nothing pending: send_now %0b release_time %0d",
                 result.send_now, result.release_time);
          errors++;
        end else begin
          e = pending_decisions.pop_front();
          if (result.send_now !== e.send_now) begin
            $error("send_now expected %0b got %0b", e.send_now, result.send_now);
            errors++;
          end
          if (result.release_time !== e.release_time) begin
            $error("release_time expected %0d got %0d", e.release_time, result.release_time);
            errors++;
          end
        end
      end
      if (item_valid && item_ready) begin
        if (decide_packet(item, p)) pending_decisions.push_back(pin_on ? pin_val : p);
      end
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
    end
  end

  // Result side: random stall bursts, none once calm
  initial begin
    int hold;
    hold = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        result_ready <= 1'b1;
      end else if (hold == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          result_ready <= 1'b0;
          hold = $urandom_range(1, 17);
        end else begin
          result_ready <= 1'b1;
          hold = $urandom_range(1, 40);
        end
      end else begin
        hold--;
      end
    end
  end

  // Present one item, with an optional gap first; called and returns at a falling edge
  task automatic push_item(input osp_pkg::in_item_t it, input bit pin,
                           input osp_pkg::out_item_t pv);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    pin_on <= pin;
    pin_val <= pv;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input osp_pkg::cfg_index_t idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every pending result is back and the pipe is empty
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int ph);
    logic [15:0] ivl, ahd, rate;
    logic [31:0] w;
    case (ph)
      0: begin ivl = 16'd0;     w = 32'hFFFF_FFFF; ahd = 16'd20;    rate = 16'd512;   end
      1: begin ivl = 16'hFFFF;  w = 32'hFFFF_FFFF; ahd = 16'hFFFF;  rate = 16'hFFFF;  end
      2: begin ivl = 16'd1;     w = 32'd0;         ahd = 16'd0;     rate = 16'd0;     end
      3: begin ivl = 16'd200;   w = 32'h7FFF_FFFF; ahd = 16'd20;    rate = 16'd255;   end
      4: begin ivl = 16'd50;    w = 32'd200000;    ahd = 16'd5;     rate = 16'd256;   end
      5: begin ivl = 16'd200;   w = 32'hFFFF_FFFF; ahd = 16'd1;     rate = 16'd1024;  end
      default: begin
        case ($urandom_range(0, 5))
          0: ivl = 16'($urandom);
          1: ivl = 16'd0;
          default: ivl = 16'($urandom_range(1, 1000));
        endcase
        case ($urandom_range(0, 2))
          0: w = 32'hFFFF_FFFF;
          1: w = 32'($urandom_range(0, 300000));
          default: w = $urandom & 32'h7FFF_FFFF;
        endcase
        ahd = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
        rate = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
      end
    endcase
    // upper data bits are don't-care for the 16-bit registers; toggle them anyway
    write_reg(osp_pkg::CFG_SEND_INTERVAL, {16'($urandom), ivl});
    write_reg(osp_pkg::CFG_MAX_AHEAD, {16'($urandom), ahd});
    write_reg(osp_pkg::CFG_RATE, {16'($urandom), rate});
    write_reg(osp_pkg::CFG_INIT_WINDOW, w);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Bound the run
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    errors = 0;
    calm = 1'b0;
    stream_ms = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    pin_on = 1'b0;
    pin_val = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // due soon at zero and at the top of the time range
    add_row(mk(osp_pkg::OP_CHECK, 48'd0, 48'd0, 16'd0, 32'd0), 1, 1'b1, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, osp_pkg::TIME_MAX, osp_pkg::TIME_MAX, 16'hFFFF,
               32'hFFFF_FFFF), 1, 1'b1, 48'd0);
    add_row(mk(osp_pkg::OP_RESET_WINDOW, osp_pkg::TIME_MAX, osp_pkg::TIME_MAX, 16'hFFFF,
               32'hFFFF_FFFF), 0, 1'b0, 48'd0);
    // rate cap after the first bucket roll, then the due-soon boundary
    add_row(mk(osp_pkg::OP_CHECK, 48'd2201, 48'd1000, 16'd100, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd2200, 48'd1000, 16'd100, 32'd0), 1, 1'b1, 48'd0);
    // maximum send-ahead, then keeping ahead across a roll
    add_row(mk(osp_pkg::OP_CHECK, 48'd31100, 48'd1100, 16'd100, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd2400, 48'd1100, 16'd100, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd2750, 48'd1500, 16'd100, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_ADD_BYTES, 48'd0, 48'd0, 16'hFFFF, 32'd0), 0, 1'b0, 48'd0);
    // window zero releases at the due time
    add_row(mk(osp_pkg::OP_SET_WINDOW, 48'd0, 48'd0, 16'd0, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd5000, 48'd2000, 16'd100, 32'd0), 1, 1'b0, 48'd5000);
    // low client window, on both sides of the limit
    add_row(mk(osp_pkg::OP_SET_WINDOW, 48'd0, 48'd0, 16'd0, 32'd1000), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd5000, 48'd2000, 16'd201, 32'd0), 1, 1'b0, 48'd3000);
    add_row(mk(osp_pkg::OP_CHECK, 48'd5000, 48'd2000, 16'd200, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_ADD_BYTES, 48'd0, 48'd0, 16'd1, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd5000, 48'd2000, 16'd200, 32'd0), 1, 1'b0, 48'd3000);
    add_row(mk(osp_pkg::OP_SET_WINDOW, 48'd0, 48'd0, 16'd0, 32'h7FFF_FFFF), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd5000, 48'd2000, 16'hFFFF, 32'd0), 0, 1'b0, 48'd0);
    // most negative window always counts as low
    add_row(mk(osp_pkg::OP_SET_WINDOW, 48'd0, 48'd0, 16'd0, 32'h8000_0000), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd5000, 48'd2000, 16'd0, 32'd0), 1, 1'b0, 48'd3000);
    add_row(mk(osp_pkg::OP_SET_WINDOW, 48'd0, 48'd0, 16'd0, 32'hFFFF_FFFF), 0, 1'b0, 48'd0);
    // time running backward with a far due time
    add_row(mk(osp_pkg::OP_CHECK, osp_pkg::TIME_MAX, 48'd0, 16'd100, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_RESET_WINDOW, 48'd0, 48'd0, 16'd0, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd1206, 48'd5, 16'd100, 32'd0), 0, 1'b0, 48'd0);
    add_row(mk(osp_pkg::OP_CHECK, 48'd3000, 48'd900, 16'd1500, 32'd0), 0, 1'b0, 48'd0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table at reset settings
    foreach (plan[i]) push_item(plan[i].it, plan[i].pin, plan[i].want);
    drain();

    // random phases, each under its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) calm = 1'b1;
      configure(ph);
      stream_ms = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 10000))
                                              : 64'({8'($urandom), $urandom});
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_item(draw_item(), 1'b0, '0);
      drain();
    end

    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### overbuffer_send_pacer_core.f
rtl/osp_pkg.sv
rtl/osp_cfg_regs.sv
rtl/osp_decide.sv
rtl/overbuffer_send_pacer_core.sv
bench/tb.sv
